/* sv/phpu_pkg.sv */
// ----------------------------------------------------------------------------
// phpu_pkg
// Shared types and constants for the particle heading/position update block.
// ----------------------------------------------------------------------------
package phpu_pkg;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_WORLD_WIDTH   = 3'd0,
      CSR_WORLD_HEIGHT  = 3'd1,
      CSR_FIXED_TURN    = 3'd2,
      CSR_NEIGHBOR_TURN = 3'd3,
      CSR_STEP_SPEED    = 3'd4,
      CSR_TURN_NOISE    = 3'd5
   } csr_index_type;

   localparam logic [31:0] WORLD_WIDTH_RST  = 32'd41943040;
   localparam logic [31:0] WORLD_HEIGHT_RST = 32'd41943040;
   localparam logic [23:0] STEP_SPEED_RST   = 24'd65536;

   typedef struct packed {
      logic [31:0]        world_width;
      logic [31:0]        world_height;
      logic signed [15:0] fixed_turn;
      logic signed [15:0] neighbor_turn;
      logic [23:0]        step_speed;
      logic signed [15:0] turn_noise;
   } cfg_type;

   // Item after heading update, waiting for the motion pipeline.
   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [15:0] heading;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // CORDIC: 15 rotations, Q24 vectors, angles in turn/65536.
   localparam int CORDIC_STEPS = 15;
   localparam logic signed [26:0] CORDIC_GAIN = 27'sd10188014;
   localparam logic signed [16:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
      17'sd8192, 17'sd4836, 17'sd2555, 17'sd1297, 17'sd651, 17'sd326,
      17'sd163, 17'sd81, 17'sd41, 17'sd20, 17'sd10, 17'sd5, 17'sd3,
      17'sd1, 17'sd1
   };

   // Width of the magnitude fed to the position remainder unit.
   localparam int MAG_W = 34;

endpackage

/* sv/phpu_if.sv */
// ----------------------------------------------------------------------------
// phpu request / response channels
// Valid/ready channels carrying one particle in and one update out.
// ----------------------------------------------------------------------------
interface phpu_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [15:0] heading;
   logic [7:0]  left_count;
   logic [7:0]  right_count;
   logic [8:0]  neighbor_count;

   modport source (output valid, pos_x, pos_y, heading, left_count, right_count,
                   neighbor_count, input ready);
   modport sink   (input valid, pos_x, pos_y, heading, left_count, right_count,
                   neighbor_count, output ready);
endinterface

interface phpu_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        new_x;
   logic [31:0]        new_y;
   logic [15:0]        new_heading;
   logic signed [15:0] cos_out;
   logic signed [15:0] sin_out;

   modport source (output valid, new_x, new_y, new_heading, cos_out, sin_out,
                   input ready);
   modport sink   (input valid, new_x, new_y, new_heading, cos_out, sin_out,
                   output ready);
endinterface

/* sv/phpu_front.sv */
// ----------------------------------------------------------------------------
// phpu_front
// Accepts particles, works out the new heading and registers the item.
// ----------------------------------------------------------------------------
module phpu_front (
   input  logic              clock,
   input  logic              reset,
   phpu_req_if.sink          req,
   input  phpu_pkg::cfg_type cfg,
   output phpu_pkg::item_type item_out,
   output logic              item_valid,
   input  logic              item_ready
);
   import phpu_pkg::*;

   logic               v_ff, v_in;
   item_type           it_ff, it_in;
   logic signed [25:0] side_prod;
   logic [15:0]        side;
   logic               take;

   assign req.ready = !v_ff || item_ready;
   assign take      = req.valid && req.ready;

   // Only the low 16 bits of the turn matter after the wrap.
   assign side_prod = cfg.neighbor_turn * $signed({1'b0, req.neighbor_count});

   always_comb begin
      if (req.right_count < req.left_count) begin
         side = 16'(16'd0 - side_prod[15:0]);
      end else if (req.right_count == req.left_count) begin
         side = 16'd0;
      end else begin
         side = side_prod[15:0];
      end
      it_in.pos_x   = req.pos_x;
      it_in.pos_y   = req.pos_y;
      it_in.heading = 16'(req.heading + unsigned'(cfg.fixed_turn) + side
                          + unsigned'(cfg.turn_noise));
      v_in = take || (v_ff && !item_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      if (take) begin
         it_ff <= it_in;
      end
   end

   assign item_out   = it_ff;
   assign item_valid = v_ff;
endmodule

/* sv/phpu_queue.sv */
// ----------------------------------------------------------------------------
// phpu_queue
// Short FIFO between the heading front end and the motion back end.
// ----------------------------------------------------------------------------
module phpu_queue #(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  phpu_pkg::item_type         push_item,
   input  logic                       pop,
   output phpu_pkg::item_type         pop_item,
   output phpu_pkg::queue_status_type status
);
   import phpu_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem [0:DEPTH-1];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ff + 1'b1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ff + 1'b1);
      end
      if (push && !pop) begin
         cnt_in = CW'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = CW'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem[wr_ff] <= push_item;
      end
   end

   assign pop_item     = mem[rd_ff];
   assign status.full  = (cnt_ff == CW'(DEPTH));
   assign status.empty = (cnt_ff == '0);
endmodule

/* sv/phpu_back.sv */
// ----------------------------------------------------------------------------
// phpu_back
// Motion pipeline: CORDIC sine/cosine, speed multiply, toroidal wrap by a
// bit-per-stage remainder, output register.
// ----------------------------------------------------------------------------
module phpu_back (
   input  logic               clock,
   input  logic               reset,
   input  phpu_pkg::cfg_type  cfg,
   input  phpu_pkg::item_type item_in,
   input  logic               item_valid,
   output logic               item_pop,
   phpu_rsp_if.source         rsp
);
   import phpu_pkg::*;

   localparam int DIV_N  = MAG_W;                 // remainder stages
   // load, rotations, round, multiply, wrap-sum, remainder bits, output
   localparam int NSTAGE = 1 + CORDIC_STEPS + 1 + 1 + 1 + DIV_N + 1;

   typedef struct packed {
      logic [15:0]        heading;
      logic signed [15:0] c;
      logic signed [15:0] s;
      logic               neg_x;
      logic               neg_y;
   } side_type;

   logic              adv;
   logic [NSTAGE-1:0] v_ff, v_in;

   // CORDIC section
   logic signed [26:0] cx_ff [0:CORDIC_STEPS];
   logic signed [26:0] cy_ff [0:CORDIC_STEPS];
   logic signed [16:0] cz_ff [0:CORDIC_STEPS];
   logic [1:0]         cq_ff [0:CORDIC_STEPS];
   item_type           ci_ff [0:CORDIC_STEPS];

   // round / rotate, multiply
   logic signed [15:0] rc_ff, rs_ff;
   item_type           ri_ff;
   logic signed [40:0] px_ff, py_ff;
   logic signed [15:0] mc_ff, ms_ff;
   item_type           mi_ff;

   // remainder section
   logic [32:0]      rx_ff [0:DIV_N];
   logic [32:0]      ry_ff [0:DIV_N];
   logic [MAG_W-1:0] ax_ff [0:DIV_N];
   logic [MAG_W-1:0] ay_ff [0:DIV_N];
   side_type         sb_ff [0:DIV_N];

   logic [31:0]        ox_ff, oy_ff;
   side_type           ob_ff;

   logic [1:0]         q0;
   logic signed [15:0] rq_c, rq_s, rot_c, rot_s;
   logic signed [26:0] dx, dy;
   logic signed [33:0] sx, sy;
   logic [32:0]        mod_x, mod_y;

   function automatic logic signed [15:0] to_q14(input logic signed [26:0] v);
      logic signed [26:0] t;
      logic signed [16:0] r;
      t = v + 27'sd512;
      r = t[26:10];
      if (r > 17'sd16384) begin
         r = 17'sd16384;
      end else if (r < -17'sd16384) begin
         r = -17'sd16384;
      end
      return r[15:0];
   endfunction

   assign adv      = !v_ff[NSTAGE-1] || rsp.ready;
   assign item_pop = adv && item_valid;
   assign v_in     = {v_ff[NSTAGE-2:0], item_pop};

   assign mod_x = (cfg.world_width == '0)  ? {1'b1, 32'd0} : {1'b0, cfg.world_width};
   assign mod_y = (cfg.world_height == '0) ? {1'b1, 32'd0} : {1'b0, cfg.world_height};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // Quadrant split: residual angle lands in [-8192, 8191].
   assign q0 = 2'(({1'b0, item_in.heading} + 17'd8192) >> 14);

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff[0] <= CORDIC_GAIN;
         cy_ff[0] <= '0;
         cz_ff[0] <= 17'(signed'(16'(item_in.heading - {q0, 14'd0})));
         cq_ff[0] <= q0;
         ci_ff[0] <= item_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!cz_ff[i][16]) begin
               cx_ff[i+1] <= cx_ff[i] - (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] + (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] - ATAN_TAB[i];
            end else begin
               cx_ff[i+1] <= cx_ff[i] + (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] - (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] + ATAN_TAB[i];
            end
            cq_ff[i+1] <= cq_ff[i];
            ci_ff[i+1] <= ci_ff[i];
         end
      end
   end

   // Round to Q1.14 and rotate back into the quadrant.
   always_comb begin
      rq_c = to_q14(cx_ff[CORDIC_STEPS]);
      rq_s = to_q14(cy_ff[CORDIC_STEPS]);
      case (cq_ff[CORDIC_STEPS])
         2'd0: begin
            rot_c = rq_c;
            rot_s = rq_s;
         end
         2'd1: begin
            rot_c = -rq_s;
            rot_s = rq_c;
         end
         2'd2: begin
            rot_c = -rq_c;
            rot_s = -rq_s;
         end
         default: begin
            rot_c = rq_s;
            rot_s = -rq_c;
         end
      endcase
   end

   // Rounded speed product, then position sum and its sign/magnitude.
   assign dx = 27'((px_ff + 41'sd8192) >>> 14);
   assign dy = 27'((py_ff + 41'sd8192) >>> 14);
   assign sx = $signed({2'b00, mi_ff.pos_x}) + 34'(dx);
   assign sy = $signed({2'b00, mi_ff.pos_y}) + 34'(dy);

   always_ff @(posedge clock) begin
      if (adv) begin
         rc_ff <= rot_c;
         rs_ff <= rot_s;
         ri_ff <= ci_ff[CORDIC_STEPS];

         px_ff <= $signed({1'b0, cfg.step_speed}) * rc_ff;
         py_ff <= $signed({1'b0, cfg.step_speed}) * rs_ff;
         mc_ff <= rc_ff;
         ms_ff <= rs_ff;
         mi_ff <= ri_ff;

         rx_ff[0] <= '0;
         ry_ff[0] <= '0;
         ax_ff[0] <= sx[33] ? MAG_W'(-sx) : MAG_W'(sx);
         ay_ff[0] <= sy[33] ? MAG_W'(-sy) : MAG_W'(sy);
         sb_ff[0] <= '{heading: mi_ff.heading, c: mc_ff, s: ms_ff,
                       neg_x: sx[33], neg_y: sy[33]};
      end
   end

   // One quotient bit per stage; only the remainder is kept.
   for (genvar k = 0; k < DIV_N; k++) begin : g_rem
      logic [33:0] tx, ty;
      assign tx = {rx_ff[k], ax_ff[k][MAG_W-1]};
      assign ty = {ry_ff[k], ay_ff[k][MAG_W-1]};
      always_ff @(posedge clock) begin
         if (adv) begin
            rx_ff[k+1] <= (tx >= {1'b0, mod_x}) ? 33'(tx - {1'b0, mod_x}) : tx[32:0];
            ry_ff[k+1] <= (ty >= {1'b0, mod_y}) ? 33'(ty - {1'b0, mod_y}) : ty[32:0];
            ax_ff[k+1] <= {ax_ff[k][MAG_W-2:0], 1'b0};
            ay_ff[k+1] <= {ay_ff[k][MAG_W-2:0], 1'b0};
            sb_ff[k+1] <= sb_ff[k];
         end
      end
   end

   // Fold a negative sum back to the nonnegative remainder.
   always_ff @(posedge clock) begin
      if (adv) begin
         ox_ff <= (sb_ff[DIV_N].neg_x && rx_ff[DIV_N] != '0)
                  ? 32'(mod_x - rx_ff[DIV_N]) : rx_ff[DIV_N][31:0];
         oy_ff <= (sb_ff[DIV_N].neg_y && ry_ff[DIV_N] != '0)
                  ? 32'(mod_y - ry_ff[DIV_N]) : ry_ff[DIV_N][31:0];
         ob_ff <= sb_ff[DIV_N];
      end
   end

   assign rsp.valid       = v_ff[NSTAGE-1];
   assign rsp.new_x       = ox_ff;
   assign rsp.new_y       = oy_ff;
   assign rsp.new_heading = ob_ff.heading;
   assign rsp.cos_out     = ob_ff.c;
   assign rsp.sin_out     = ob_ff.s;
endmodule

/* sv/particle_heading_position_update_top.sv */
// ----------------------------------------------------------------------------
// particle_heading_position_update_top
// Turns a particle's heading by fixed, neighbor and noise terms, gives the
// cosine/sine of the new heading and moves the particle with toroidal wrap.
//
//   channel   dir  handshake          payload
//   req_chan  in   valid/ready        pos_x, pos_y, heading, left/right/neighbor count
//   rsp_chan  out  valid/ready        new_x, new_y, new_heading, cos_out, sin_out
//   csr_*     in   csr_we (no ready)  csr_index, csr_wdata
//
// One particle per cycle sustained while rsp_chan is ready. From a transfer on
// req_chan to rsp_chan valid, the front register loads at the transfer edge,
// the item is then written to the queue and passes 54 back-end stages (input load,
// 15 CORDIC rotations, round, multiply, wrap-sum, 34 remainder bits, output).
// The 34-bit position remainder, one bit per stage, sets the depth.
// Reset is synchronous; it clears valid and queue state and loads register defaults.
// A stall on rsp_chan freezes the back end; the queue and front register
// keep taking transfers until they fill.
// ----------------------------------------------------------------------------
module particle_heading_position_update_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   phpu_req_if.sink    req_chan,
   phpu_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import phpu_pkg::*;

   cfg_type          cfg_ff;
   item_type         front_item, queue_item;
   logic             front_valid, q_push, q_pop;
   queue_status_type q_st;

   // Register file: write only while the block is idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.world_width   <= WORLD_WIDTH_RST;
         cfg_ff.world_height  <= WORLD_HEIGHT_RST;
         cfg_ff.fixed_turn    <= '0;
         cfg_ff.neighbor_turn <= '0;
         cfg_ff.step_speed    <= STEP_SPEED_RST;
         cfg_ff.turn_noise    <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_WORLD_WIDTH:   cfg_ff.world_width   <= csr_wdata;
            CSR_WORLD_HEIGHT:  cfg_ff.world_height  <= csr_wdata;
            CSR_FIXED_TURN:    cfg_ff.fixed_turn    <= signed'(csr_wdata[15:0]);
            CSR_NEIGHBOR_TURN: cfg_ff.neighbor_turn <= signed'(csr_wdata[15:0]);
            CSR_STEP_SPEED:    cfg_ff.step_speed    <= csr_wdata[23:0];
            CSR_TURN_NOISE:    cfg_ff.turn_noise    <= signed'(csr_wdata[15:0]);
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   // Front: take the transfer and compute the new heading.
   phpu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .cfg        (cfg_ff),
      .item_out   (front_item),
      .item_valid (front_valid),
      .item_ready (!q_st.full)
   );

   assign q_push = front_valid && !q_st.full;

   // Queue: decouple front and back stalls.
   phpu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .pop_item  (queue_item),
      .status    (q_st)
   );

   // Back: sine/cosine, motion and wrap.
   phpu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_in    (queue_item),
      .item_valid (!q_st.empty),
      .item_pop   (q_pop),
      .rsp        (rsp_chan)
   );

   // Never pop an empty queue.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_st.empty) else $error("pop from empty queue");

   // A push with no pop leaves the queue holding something.
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> !q_st.empty) else $error("pushed item lost");

   // Cosine and sine stay within Q1.14 unit range.
   a_trig_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.cos_out <= 16'sd16384 &&
                          rsp_chan.cos_out >= -16'sd16384 &&
                          rsp_chan.sin_out <= 16'sd16384 &&
                          rsp_chan.sin_out >= -16'sd16384))
      else $error("cos/sin out of range");
endmodule
